### sv/dta_pkg.sv
// ----------------------------------------------------------------------------
// dta_pkg: shared constants and helpers for the dihedral angle unit
// ----------------------------------------------------------------------------
package dta_pkg;

	localparam int COORD_BITS_DEF      = 24;
	localparam int ANGLE_FRAC_BITS_DEF = 8;
	localparam int INT_FRAC            = 16;
	localparam int CORDIC_STEPS        = 23;
	localparam int NORM_BITS           = 30;
	localparam int ANG_W               = 25;   // internal angle, 2^-16 degree units
	localparam logic [ANG_W-1:0] DEG90    = ANG_W'(90 << INT_FRAC);
	localparam logic [ANG_W-1:0] DEG180   = ANG_W'(180 << INT_FRAC);
	localparam logic [ANG_W-1:0] CLAMP_LO = ANG_W'(5310);

	function automatic logic [ANG_W-1:0] atan_lut(input int i);
		logic [ANG_W-1:0] v;
		begin
			unique case (i)
				0: v = 25'd2949120;  1: v = 25'd1740967;  2: v = 25'd919879;
				3: v = 25'd466945;   4: v = 25'd234379;   5: v = 25'd117304;
				6: v = 25'd58666;    7: v = 25'd29335;    8: v = 25'd14668;
				9: v = 25'd7334;     10: v = 25'd3667;    11: v = 25'd1833;
				12: v = 25'd917;     13: v = 25'd458;     14: v = 25'd229;
				15: v = 25'd115;     16: v = 25'd57;      17: v = 25'd29;
				18: v = 25'd14;      19: v = 25'd7;       20: v = 25'd4;
				21: v = 25'd2;       22: v = 25'd1;
				default: v = '0;
			endcase
			return v;
		end
	endfunction

endpackage

### sv/dihedral_torsion_angle_unit_top.sv
// ----------------------------------------------------------------------------
// dihedral_torsion_angle_unit_top: signed dihedral angle of four 3D points
// ----------------------------------------------------------------------------
// channel   dir  payload
// s_axis    in   12 coordinates, pa_x lowest .. pd_z highest
// m_axis    out  angle_deg [16:0], degenerate [17]
//
// One item per cycle while the output is not stalled. The pipeline is a single
// stalled chain: every stage advances when the output register is empty or
// taken. It holds ten front stages, the 63-step square root, two normalize
// stages, the 23 CORDIC steps and the output register, one step per stage.
// Reset clears only valid bits. A stall holds every stage; nothing is
// dropped or repeated.
// ----------------------------------------------------------------------------
module dihedral_torsion_angle_unit_top
	import dta_pkg::*;
#(
	parameter int COORD_BITS      = COORD_BITS_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// pa_x,pa_y,pa_z,pb_x,..,pd_z from bit 0 up, COORD_BITS each
	input  logic [12*COORD_BITS-1:0]  s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// angle_deg (ANGLE_FRAC_BITS+9), degenerate, zero fill to bytes
	output logic [((ANGLE_FRAC_BITS+10+7)/8)*8-1:0] m_axis_tdata
);
	localparam int AW   = ANGLE_FRAC_BITS + 9;
	localparam int OW   = ((ANGLE_FRAC_BITS + 10 + 7) / 8) * 8;
	localparam int BW   = COORD_BITS + 1;          // bond
	localparam int NW   = 2 * BW + 2;              // normal component
	localparam int DW   = NW + BW + 2;             // triple product
	localparam int SQW  = 2 * NORM_BITS + 2 + 1;   // |cross| component magnitude
	localparam int SSW  = 2 * SQW + 2;             // sum of squares
	localparam int XW   = 2 * NORM_BITS + 3;       // dot
	localparam int CW   = NORM_BITS + 3;           // cordic x/y
	localparam int SQ_STEPS = 63;
	localparam int LOW  = NW / 2;                  // low part of a split normal

	logic adv;
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// ---------------- stage 1: bonds
	logic signed [COORD_BITS-1:0] p [12];
	logic signed [BW-1:0] b0_s1 [3], b1_s1 [3], b2_s1 [3];
	logic v_s1;
	always_comb begin
		for (int i = 0; i < 12; i++) p[i] = s_axis_tdata[i*COORD_BITS +: COORD_BITS];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				b0_s1[i] <= BW'(p[3+i]) - BW'(p[i]);
				b1_s1[i] <= BW'(p[6+i]) - BW'(p[3+i]);
				b2_s1[i] <= BW'(p[9+i]) - BW'(p[6+i]);
			end
		end
	end

	// ---------------- stage 2: products, stage 3: normals
	logic signed [2*BW-1:0] pr_s2 [12];
	logic signed [BW-1:0] b0_s2 [3];
	logic v_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			pr_s2[0]  <= b0_s1[1]*b1_s1[2]; pr_s2[1]  <= b0_s1[2]*b1_s1[1];
			pr_s2[2]  <= b0_s1[2]*b1_s1[0]; pr_s2[3]  <= b0_s1[0]*b1_s1[2];
			pr_s2[4]  <= b0_s1[0]*b1_s1[1]; pr_s2[5]  <= b0_s1[1]*b1_s1[0];
			pr_s2[6]  <= b1_s1[1]*b2_s1[2]; pr_s2[7]  <= b1_s1[2]*b2_s1[1];
			pr_s2[8]  <= b1_s1[2]*b2_s1[0]; pr_s2[9]  <= b1_s1[0]*b2_s1[2];
			pr_s2[10] <= b1_s1[0]*b2_s1[1]; pr_s2[11] <= b1_s1[1]*b2_s1[0];
			b0_s2 <= b0_s1;
		end
	end
	logic signed [NW-1:0] n0_s3 [3], n1_s3 [3];
	logic signed [BW-1:0] b0_s3 [3];
	logic v_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				n0_s3[i] <= NW'(pr_s2[2*i]) - NW'(pr_s2[2*i+1]);
				n1_s3[i] <= NW'(pr_s2[6+2*i]) - NW'(pr_s2[7+2*i]);
			end
			b0_s3 <= b0_s2;
		end
	end

	// ---------------- stage 4: triple product partials, magnitudes, degenerate
	// split each n1 component into a signed high and an unsigned low half
	logic signed [BW+LOW:0] tpl_s4 [3];
	logic signed [BW+NW-LOW-1:0] tph_s4 [3];
	logic [NW-1:0] mg0_s4 [3], mg1_s4 [3];
	logic [2:0] ng0_s4, ng1_s4;
	logic dg_s4, v_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				tpl_s4[i] <= b0_s3[i] * $signed({1'b0, n1_s3[i][LOW-1:0]});
				tph_s4[i] <= b0_s3[i] * $signed(n1_s3[i][NW-1:LOW]);
				ng0_s4[i] <= n0_s3[i][NW-1];
				ng1_s4[i] <= n1_s3[i][NW-1];
				mg0_s4[i] <= n0_s3[i][NW-1] ? NW'(-n0_s3[i]) : NW'(n0_s3[i]);
				mg1_s4[i] <= n1_s3[i][NW-1] ? NW'(-n1_s3[i]) : NW'(n1_s3[i]);
			end
			dg_s4 <= (n0_s3[0] == '0 && n0_s3[1] == '0 && n0_s3[2] == '0) ||
			         (n1_s3[0] == '0 && n1_s3[1] == '0 && n1_s3[2] == '0);
		end
	end

	// ---------------- stage 5: triple product sum, reduction shift
	function automatic int blen(input logic [NW-1:0] v);
		int n;
		begin
			n = 0;
			for (int k = 0; k < NW; k++) if (v[k]) n = k + 1;
			return n;
		end
	endfunction
	localparam int SHW = $clog2(NW + 1);
	logic dg_s5, v_s5;
	logic signed [DW+1:0] det_s5;
	logic [NW-1:0] mg0_s5 [3], mg1_s5 [3];
	logic [2:0] ng0_s5, ng1_s5;
	logic [SHW-1:0] sh0_s5, sh1_s5;
	logic signed [DW+1:0] det;
	always_comb begin
		det = '0;
		for (int i = 0; i < 3; i++)
			det = det + ((DW+2)'(tph_s4[i]) << LOW) + (DW+2)'(tpl_s4[i]);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			int l0, l1;
			l0 = blen(mg0_s4[0] | mg0_s4[1] | mg0_s4[2]);
			l1 = blen(mg1_s4[0] | mg1_s4[1] | mg1_s4[2]);
			sh0_s5 <= SHW'(l0 > NORM_BITS ? l0 - NORM_BITS : 0);
			sh1_s5 <= SHW'(l1 > NORM_BITS ? l1 - NORM_BITS : 0);
			det_s5 <= det;
			mg0_s5 <= mg0_s4; mg1_s5 <= mg1_s4;
			ng0_s5 <= ng0_s4; ng1_s5 <= ng1_s4; dg_s5 <= dg_s4;
		end
	end

	// ---------------- stage 6: reduced normals, triple sign
	logic signed [NORM_BITS:0] m0_s6 [3], m1_s6 [3];
	logic pos_s6, dg_s6, v_s6;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				logic [NW-1:0] a0, a1;
				a0 = mg0_s5[i] >> sh0_s5;
				a1 = mg1_s5[i] >> sh1_s5;
				m0_s6[i] <= ng0_s5[i] ? -$signed({1'b0, a0[NORM_BITS-1:0]})
				                      : $signed({1'b0, a0[NORM_BITS-1:0]});
				m1_s6[i] <= ng1_s5[i] ? -$signed({1'b0, a1[NORM_BITS-1:0]})
				                      : $signed({1'b0, a1[NORM_BITS-1:0]});
			end
			pos_s6 <= !det_s5[DW+1] && det_s5 != '0;
			dg_s6 <= dg_s5;
		end
	end

	// ---------------- stage 7: 31x31 products
	logic signed [2*NORM_BITS+1:0] q_s7 [9];
	logic pos_s7, dg_s7, v_s7;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) q_s7[i] <= m0_s6[i] * m1_s6[i];
			q_s7[3] <= m0_s6[1]*m1_s6[2]; q_s7[4] <= m0_s6[2]*m1_s6[1];
			q_s7[5] <= m0_s6[2]*m1_s6[0]; q_s7[6] <= m0_s6[0]*m1_s6[2];
			q_s7[7] <= m0_s6[0]*m1_s6[1]; q_s7[8] <= m0_s6[1]*m1_s6[0];
			pos_s7 <= pos_s6; dg_s7 <= dg_s6;
		end
	end

	// ---------------- stage 8: dot, cross magnitudes
	logic signed [XW-1:0] x_s8;
	logic [SQW-1:0] c_s8 [3];
	logic pos_s8, dg_s8, v_s8;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [SQW:0] d;
				d = (SQW+1)'(q_s7[3+2*i]) - (SQW+1)'(q_s7[4+2*i]);
				c_s8[i] <= d[SQW] ? SQW'(-d) : SQW'(d);
			end
			x_s8 <= XW'(q_s7[0]) + XW'(q_s7[1]) + XW'(q_s7[2]);
			pos_s8 <= pos_s7; dg_s8 <= dg_s7;
		end
	end

	// ---------------- stage 9: squares (split 32-bit pieces), stage 10 sum
	localparam int HW = (SQW + 1) / 2;
	logic [2*HW-1:0] sl_s9 [3], sh_s9 [3];
	logic [2*HW:0]   sm_s9 [3];
	logic signed [XW-1:0] x_s9;
	logic pos_s9, dg_s9, v_s9;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				logic [HW-1:0] lo, hi;
				{hi, lo} = (2*HW)'(c_s8[i]);
				sl_s9[i] <= lo * lo;
				sh_s9[i] <= hi * hi;
				sm_s9[i] <= (2*HW+1)'(lo * hi) << 1;
			end
			x_s9 <= x_s8; pos_s9 <= pos_s8; dg_s9 <= dg_s8;
		end
	end
	logic [SSW-1:0] ss_s10;
	logic signed [XW-1:0] x_s10;
	logic pos_s10, dg_s10, v_s10;
	always_ff @(posedge clk) begin
		if (adv) begin
			logic [SSW-1:0] acc, cs;
			acc = '0;
			// low and high squares do not overlap: join them, add the middle term
			for (int i = 0; i < 3; i++) begin
				cs = SSW'({sh_s9[i], sl_s9[i]}) + (SSW'(sm_s9[i]) << HW);
				acc = acc + cs;
			end
			ss_s10 <= acc;
			x_s10 <= x_s9; pos_s10 <= pos_s9; dg_s10 <= dg_s9;
		end
	end

	// ---------------- square root: one result bit per stage (restoring)
	localparam int RW = SQ_STEPS;
	logic [SSW-1:0] rem_q [SQ_STEPS+1];
	logic [RW-1:0]  rt_q  [SQ_STEPS+1];
	logic signed [XW-1:0] xs_q [SQ_STEPS+1];
	logic [SQ_STEPS:0] pos_q, dg_q, vs_q;
	assign rem_q[0] = ss_s10; assign rt_q[0] = '0; assign xs_q[0] = x_s10;
	assign pos_q[0] = pos_s10; assign dg_q[0] = dg_s10; assign vs_q[0] = v_s10;
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		localparam int BIT = SQ_STEPS - 1 - k;
		logic [SSW+1:0] t, sq_cur, sq_new;
		// (r+2^b)^2 = r^2 + r*2^(b+1) + 2^(2b); track remainder s - r^2
		always_comb begin
			t = (SSW+2)'(rt_q[k]) << (BIT + 1);
			t = t + ((SSW+2)'(1) << (2*BIT));
			sq_cur = (SSW+2)'(rem_q[k]);
			sq_new = sq_cur - t;
		end
		logic [SSW-1:0] rem_r; logic [RW-1:0] rt_r; logic signed [XW-1:0] x_r;
		logic pos_r, dg_r, v_r;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_r <= 1'b0;
			else if (adv) v_r <= vs_q[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (t <= sq_cur) begin
					rem_r <= SSW'(sq_new); rt_r <= rt_q[k] | (RW'(1) << BIT);
				end else begin
					rem_r <= rem_q[k]; rt_r <= rt_q[k];
				end
				x_r <= xs_q[k]; pos_r <= pos_q[k]; dg_r <= dg_q[k];
			end
		end
		assign rem_q[k+1] = rem_r; assign rt_q[k+1] = rt_r; assign xs_q[k+1] = x_r;
		assign pos_q[k+1] = pos_r; assign dg_q[k+1] = dg_r; assign vs_q[k+1] = v_r;
	end

	// ---------------- normalize |x|, y
	localparam int LW = $clog2(XW + 1);
	logic [XW-1:0] ax_n, y_n;
	logic [LW-1:0] ln_n;
	logic xng_n;
	always_comb begin
		logic [XW-1:0] mx;
		int n;
		xng_n = xs_q[SQ_STEPS][XW-1];
		ax_n = xng_n ? XW'(-xs_q[SQ_STEPS]) : XW'(xs_q[SQ_STEPS]);
		y_n = XW'(rt_q[SQ_STEPS]);
		mx = (ax_n > y_n) ? ax_n : y_n;
		n = 0;
		for (int k = 0; k < XW; k++) if (mx[k]) n = k + 1;
		ln_n = LW'(n);
	end
	logic [XW-1:0] ax_sA, y_sA; logic [LW-1:0] ln_sA;
	logic xng_sA, pos_sA, dg_sA, v_sA;
	always_ff @(posedge clk) begin
		if (adv) begin
			ax_sA <= ax_n; y_sA <= y_n; ln_sA <= ln_n; xng_sA <= xng_n;
			pos_sA <= pos_q[SQ_STEPS]; dg_sA <= dg_q[SQ_STEPS];
		end
	end
	logic signed [CW-1:0] cx_q [CORDIC_STEPS+1], cy_q [CORDIC_STEPS+1];
	logic signed [ANG_W+1:0] z_q [CORDIC_STEPS+1];
	logic [CORDIC_STEPS:0] xn_q, ps_q, dq_q, vc_q;
	logic signed [CW-1:0] cx_sB, cy_sB;
	logic xng_sB, pos_sB, dg_sB, v_sB;
	always_ff @(posedge clk) begin
		if (adv) begin
			if (ln_sA > LW'(NORM_BITS)) begin
				cx_sB <= CW'(ax_sA >> (ln_sA - LW'(NORM_BITS)));
				cy_sB <= CW'(y_sA >> (ln_sA - LW'(NORM_BITS)));
			end else begin
				cx_sB <= CW'(ax_sA << (LW'(NORM_BITS) - ln_sA));
				cy_sB <= CW'(y_sA << (LW'(NORM_BITS) - ln_sA));
			end
			xng_sB <= xng_sA; pos_sB <= pos_sA; dg_sB <= dg_sA;
		end
	end
	// zero vector leaves z = 0: with cy = 0 the loop keeps z unchanged? No:
	// it subtracts; handle the zero pair by forcing z to 0 at the end.
	logic [CORDIC_STEPS:0] zz_q;
	assign cx_q[0] = cx_sB; assign cy_q[0] = cy_sB; assign z_q[0] = '0;
	assign xn_q[0] = xng_sB; assign ps_q[0] = pos_sB; assign dq_q[0] = dg_sB;
	assign vc_q[0] = v_sB; assign zz_q[0] = (cx_sB == '0) && (cy_sB == '0);
	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
		logic signed [CW-1:0] cx_r, cy_r; logic signed [ANG_W+1:0] z_r;
		logic xn_r, ps_r, dq_r, zz_r, v_r;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_r <= 1'b0;
			else if (adv) v_r <= vc_q[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (cy_q[k] > 0) begin
					cx_r <= cx_q[k] + (cy_q[k] >>> k);
					cy_r <= cy_q[k] - (cx_q[k] >>> k);
					z_r  <= z_q[k] + $signed({2'b00, atan_lut(k)});
				end else begin
					cx_r <= cx_q[k] - (cy_q[k] >>> k);
					cy_r <= cy_q[k] + (cx_q[k] >>> k);
					z_r  <= z_q[k] - $signed({2'b00, atan_lut(k)});
				end
				xn_r <= xn_q[k]; ps_r <= ps_q[k]; dq_r <= dq_q[k]; zz_r <= zz_q[k];
			end
		end
		assign cx_q[k+1] = cx_r; assign cy_q[k+1] = cy_r; assign z_q[k+1] = z_r;
		assign xn_q[k+1] = xn_r; assign ps_q[k+1] = ps_r; assign dq_q[k+1] = dq_r;
		assign zz_q[k+1] = zz_r; assign vc_q[k+1] = v_r;
	end

	// ---------------- final: clamp, fold, round, sign
	localparam int RSH = INT_FRAC - ANGLE_FRAC_BITS;
	logic [AW-1:0] ang_c;
	always_comb begin
		logic signed [ANG_W+1:0] z;
		logic [ANG_W-1:0] th, zc;
		logic [ANG_W:0] rr;
		z = zz_q[CORDIC_STEPS] ? '0 : z_q[CORDIC_STEPS];
		if (z < 0) zc = '0;
		else if (z > $signed({2'b00, DEG90})) zc = DEG90;
		else zc = ANG_W'(z);
		th = xn_q[CORDIC_STEPS] ? DEG180 - zc : zc;
		if (th < CLAMP_LO) th = CLAMP_LO;
		if (th > DEG180 - CLAMP_LO) th = DEG180 - CLAMP_LO;
		rr = ((ANG_W+1)'(th) + ((ANG_W+1)'(1) << (RSH - 1))) >> RSH;
		if (dq_q[CORDIC_STEPS]) ang_c = '0;
		else if (ps_q[CORDIC_STEPS]) ang_c = AW'(rr);
		else ang_c = AW'(-rr);
	end
	logic [AW-1:0] ang_q; logic dg_q2, ov_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (adv) ov_q <= vc_q[CORDIC_STEPS];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ang_q <= ang_c; dg_q2 <= dq_q[CORDIC_STEPS];
		end
	end
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = OW'({dg_q2, ang_q});

	// ---------------- valid chain for the fixed stages
	dta_stage u_v1 (.clk, .arst_n, .adv, .in_vld(s_axis_tvalid), .out_vld(v_s1));
	dta_stage u_v2 (.clk, .arst_n, .adv, .in_vld(v_s1), .out_vld(v_s2));
	dta_stage u_v3 (.clk, .arst_n, .adv, .in_vld(v_s2), .out_vld(v_s3));
	dta_stage u_v4 (.clk, .arst_n, .adv, .in_vld(v_s3), .out_vld(v_s4));
	dta_stage u_v5 (.clk, .arst_n, .adv, .in_vld(v_s4), .out_vld(v_s5));
	dta_stage u_v6 (.clk, .arst_n, .adv, .in_vld(v_s5), .out_vld(v_s6));
	dta_stage u_v7 (.clk, .arst_n, .adv, .in_vld(v_s6), .out_vld(v_s7));
	dta_stage u_v8 (.clk, .arst_n, .adv, .in_vld(v_s7), .out_vld(v_s8));
	dta_stage u_v9 (.clk, .arst_n, .adv, .in_vld(v_s8), .out_vld(v_s9));
	dta_stage u_v10 (.clk, .arst_n, .adv, .in_vld(v_s9), .out_vld(v_s10));
	dta_stage u_vA (.clk, .arst_n, .adv, .in_vld(vs_q[SQ_STEPS]), .out_vld(v_sA));
	dta_stage u_vB (.clk, .arst_n, .adv, .in_vld(v_sA), .out_vld(v_sB));

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed under stall");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s5) && $stable(v_sB))
		else $error("pipeline moved while stalled");
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[AW] |-> m_axis_tdata[AW-1:0] == '0)
		else $error("degenerate item with nonzero angle");
endmodule

### sv/dta_stage.sv
// ----------------------------------------------------------------------------
// dta_stage: pipeline valid bit slot with stall
// ----------------------------------------------------------------------------
module dta_stage (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_vld,
	output logic out_vld
);
	logic vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
		end
	end

	assign out_vld = vld_s1;
endmodule
